FILE: sv/fewf_pkg.sv
// Package for the fire effect window filter: widths, reset values, register
// codes and the reciprocal used for the divide by nine.
// No dependencies.
package fewf_pkg;

	localparam int MAX_WIDTH_DEF = 256;
	localparam int MIN_WIDTH     = 3;
	localparam int HEAT_W        = 8;
	localparam int CFG_W         = 9;
	localparam int COL_W         = 10;
	localparam int SUM_W         = 12;

	// floor(x / 9) == (x * 3641) >> 15 for every 12-bit x.
	localparam int RECIP_W     = 12;
	localparam int RECIP_SHIFT = 15;
	localparam logic [RECIP_W-1:0] RECIP_9 = 12'd3641;

	localparam logic [CFG_W-1:0]  LINE_WIDTH_RST = 9'd80;
	localparam logic [HEAT_W-1:0] DECAY_RST      = 8'd2;

	typedef enum logic [0:0] {
		REG_LINE_WIDTH = 1'b0,
		REG_DECAY      = 1'b1
	} cfg_idx_t;

endpackage

FILE: sv/fewf_in_if.sv
// Input pixel channel of the fire effect window filter.
// Depends on fewf_pkg for the field widths.
interface fewf_in_if;
	logic                       valid;
	logic                       ready;
	logic [fewf_pkg::HEAT_W-1:0] heat_in;
	logic                       frame_start;

	modport source (output valid, output heat_in, output frame_start, input ready);
	modport sink   (input valid, input heat_in, input frame_start, output ready);
endinterface

FILE: sv/fewf_out_if.sv
// Result pixel channel of the fire effect window filter.
// Depends on fewf_pkg for the field widths.
interface fewf_out_if;
	logic                       valid;
	logic                       ready;
	logic [fewf_pkg::HEAT_W-1:0] heat_out;
	logic                       row_last;

	modport source (output valid, output heat_out, output row_last, input ready);
	modport sink   (input valid, input heat_out, input row_last, output ready);
endinterface

FILE: sv/fewf_line_mem.sv
// Line store memory: one write port and one read port with registered data.
// Holds both buffered rows side by side in each word. Uses no package items.
module fewf_line_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sv/fewf_col_cell.sv
// One cell of the column sum chain: holds a column sum and hands it on.
// Uses no package items.
module fewf_col_cell #(
	parameter int W = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         clr,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (en) begin
			sum_q <= clr ? '0 : d;
		end
	end

	assign q = sum_q;

endmodule

FILE: sv/fewf_cool.sv
// Cooling unit: divides a window sum by nine and subtracts the decay.
// Depends on fewf_pkg for widths and the reciprocal constant.
module fewf_cool (
	input  logic                        clk,
	input  logic                        en,
	input  logic [fewf_pkg::SUM_W-1:0]  sum,
	input  logic [fewf_pkg::HEAT_W-1:0] decay,
	output logic [fewf_pkg::HEAT_W-1:0] heat
);

	localparam int PROD_W = fewf_pkg::SUM_W + fewf_pkg::RECIP_W;
	localparam int AVG_W  = PROD_W - fewf_pkg::RECIP_SHIFT;

	logic [PROD_W-1:0] prod_s2;
	logic [AVG_W-1:0]  avg;

	// The product is registered; the subtract is combinational on its output.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PROD_W'(sum) * PROD_W'(fewf_pkg::RECIP_9);
		end
	end

	assign avg = prod_s2[PROD_W-1:fewf_pkg::RECIP_SHIFT];

	always_comb begin
		if (avg > AVG_W'(decay)) begin
			heat = fewf_pkg::HEAT_W'(avg - AVG_W'(decay));
		end else begin
			heat = '0;
		end
	end

endmodule

FILE: sv/fire_effect_window_filter.sv
// Top level of the fire effect window filter: pixel pipeline, line stores,
// column sum cells and output register. Depends on fewf_pkg, fewf_in_if,
// fewf_out_if, fewf_line_mem, fewf_col_cell and fewf_cool.
//
//   Port    Dir  Handshake        Payload
//   pix     in   valid / ready    heat_in[7:0], frame_start
//   res     out  valid / ready    heat_out[7:0], row_last
//   cfg_*   in   cfg_we only      cfg_idx (0 line_width, 1 decay), cfg_data[8:0]
//
// One pixel is taken per clock unless the output stalls. A result passes the
// line store read, the multiply and the output register. The last pixel of
// the third or later row gives two results, which leave one after the other
// through the two-entry output register. The first pixel of the next row
// gives none, so the input keeps taking one pixel per clock while the output
// is ready. Reset clears counters, column sums and valid flags; the line
// stores are not cleared. A stalled output fills the output register, then
// the multiply stage, then the read stage, and only then drops pix.ready.
module fire_effect_window_filter #(
	parameter int MAX_WIDTH = fewf_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fewf_in_if.sink                    pix,
	fewf_out_if.source                 res,
	input  logic                       cfg_we,
	input  fewf_pkg::cfg_idx_t         cfg_idx,
	input  logic [fewf_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMPW   = (AW + 1 > fewf_pkg::CFG_W) ? AW + 1 : fewf_pkg::CFG_W;
	localparam int HW     = fewf_pkg::HEAT_W;
	localparam int COLW   = fewf_pkg::COL_W;
	localparam int SUMW   = fewf_pkg::SUM_W;

	// Control fields of a pixel in the read stage.
	typedef struct packed {
		logic [AW-1:0] addr;
		logic [HW-1:0] heat;
		logic          first;
		logic          emit;
		logic          two;
	} s1_item_t;

	// Configuration registers. They must be written only while the block is idle; the block itself does not enforce this.
	logic [fewf_pkg::CFG_W-1:0] line_width_q;
	logic [HW-1:0]              decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= fewf_pkg::LINE_WIDTH_RST;
			decay_q      <= fewf_pkg::DECAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fewf_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data;
				fewf_pkg::REG_DECAY:      decay_q <= cfg_data[HW-1:0];
				default:                  decay_q <= decay_q;
			endcase
		end
	end

	// Index of the last column, after clamping the width to the legal range.
	logic [CMPW-1:0] lw_x;
	logic [CMPW-1:0] wl_x;
	logic [AW-1:0]   w_last;

	always_comb begin
		lw_x = CMPW'(line_width_q);
		priority if (lw_x < CMPW'(fewf_pkg::MIN_WIDTH)) begin
			wl_x = CMPW'(fewf_pkg::MIN_WIDTH - 1);
		end else if (lw_x > CMPW'(MAX_WIDTH)) begin
			wl_x = CMPW'(MAX_WIDTH - 1);
		end else begin
			wl_x = lw_x - CMPW'(1);
		end
	end

	assign w_last = wl_x[AW-1:0];

	// Handshake signals of the three stages.
	logic pix_acc;
	logic res_acc;
	logic s1_ready, s2_ready, s3_ready;
	logic leave1, load2, load3;

	// Input stage: the column and row counters advance as each pixel is taken.
	logic [AW-1:0] col_idx_q;
	logic [1:0]    rows_q;
	logic [AW-1:0] c_in;
	logic [1:0]    rows_base;
	logic          last_in;
	logic          full_in;

	assign pix_acc   = pix.valid && pix.ready;
	assign c_in      = pix.frame_start ? '0 : col_idx_q;
	assign rows_base = pix.frame_start ? 2'd0 : rows_q;
	assign last_in   = (c_in >= w_last);
	assign full_in   = (rows_base == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_idx_q <= '0;
			rows_q    <= '0;
		end else if (pix_acc) begin
			if (last_in) begin
				col_idx_q <= '0;
				rows_q    <= full_in ? rows_base : rows_base + 2'd1;
			end else begin
				col_idx_q <= c_in + AW'(1);
				rows_q    <= rows_base;
			end
		end
	end

	// Read stage. The line stores are read when the pixel is taken and written
	// back when it leaves this stage: the middle row moves up, the pixel enters.
	logic          v1_q;
	s1_item_t      item_s1;
	logic          fwd_s1;
	logic [HW-1:0] fwd_a_s1;
	logic [HW-1:0] fwd_b_s1;
	logic [2*HW-1:0] rd_data;
	logic [HW-1:0] above, middle;
	logic [COLW-1:0] col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (s1_ready) begin
			v1_q   <= pix_acc;
			fwd_s1 <= pix_acc && v1_q && (item_s1.addr == c_in);
		end
	end

	// A pixel read at the address that the leaving pixel writes in the same
	// cycle (frame start after a column zero pixel) takes the written values.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			item_s1.addr  <= c_in;
			item_s1.heat  <= pix.heat_in;
			item_s1.first <= (c_in == '0);
			item_s1.emit  <= full_in && (c_in != '0);
			item_s1.two   <= full_in && last_in;
			fwd_a_s1      <= middle;
			fwd_b_s1      <= item_s1.heat;
		end
	end

	fewf_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (AW),
		.DATA_W (2 * HW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (pix_acc),
		.rd_addr (c_in),
		.rd_data (rd_data),
		.wr_en   (leave1),
		.wr_addr (item_s1.addr),
		.wr_data ({middle, item_s1.heat})
	);

	assign above  = fwd_s1 ? fwd_a_s1 : rd_data[2*HW-1:HW];
	assign middle = fwd_s1 ? fwd_b_s1 : rd_data[HW-1:0];
	assign col    = COLW'(above) + COLW'(middle) + COLW'(item_s1.heat);

	// Column sum chain: the middle cell takes the new column, the left cell
	// takes the middle one. At column zero nothing lies to the left.
	logic [COLW-1:0] sum_mid, sum_left;
	logic [SUMW-1:0] win_sum, edge_sum;

	fewf_col_cell #(.W(COLW)) u_cell_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (leave1),
		.clr    (1'b0),
		.d      (col),
		.q      (sum_mid)
	);

	fewf_col_cell #(.W(COLW)) u_cell_left (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (leave1),
		.clr    (item_s1.first),
		.d      (sum_mid),
		.q      (sum_left)
	);

	assign win_sum  = SUMW'(sum_left) + SUMW'(sum_mid) + SUMW'(col);
	// The last column's window has nothing on its right side.
	assign edge_sum = SUMW'(sum_mid) + SUMW'(col);

	// Pixels without a result leave the read stage without using the next one.
	assign leave1   = v1_q && (!item_s1.emit || s2_ready);
	assign s1_ready = !v1_q || leave1;
	assign load2    = leave1 && item_s1.emit;

	// Multiply stage.
	logic v2_q;
	logic two_s2;
	logic [HW-1:0] heat0, heat1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (s2_ready) begin
			v2_q <= load2;
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			two_s2 <= item_s1.two;
		end
	end

	fewf_cool u_cool_win (
		.clk   (clk),
		.en    (load2),
		.sum   (win_sum),
		.decay (decay_q),
		.heat  (heat0)
	);

	fewf_cool u_cool_edge (
		.clk   (clk),
		.en    (load2),
		.sum   (edge_sum),
		.decay (decay_q),
		.heat  (heat1)
	);

	assign s2_ready = !v2_q || s3_ready;
	assign load3    = v2_q && s3_ready;

	// Output register with one spare entry for the second result of a row end.
	logic [1:0]    out_cnt_q;
	logic [HW-1:0] head_heat_q;
	logic          head_last_q;
	logic [HW-1:0] tail_heat_q;

	assign res_acc  = res.valid && res.ready;
	assign s3_ready = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (load3) begin
			out_cnt_q <= two_s2 ? 2'd2 : 2'd1;
		end else if (res_acc) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load3) begin
			head_heat_q <= heat0;
			head_last_q <= 1'b0;
			tail_heat_q <= heat1;
		end else if (res_acc && (out_cnt_q == 2'd2)) begin
			head_heat_q <= tail_heat_q;
			head_last_q <= 1'b1;
		end
	end

	assign pix.ready    = s1_ready;
	assign res.valid    = (out_cnt_q != 2'd0);
	assign res.heat_out = head_heat_q;
	assign res.row_last = head_last_q;

	// The first of a pair of results never closes a row.
	a_pair_head: assert property (@(posedge clk) disable iff (!arst_n)
		(out_cnt_q == 2'd2) |-> !head_last_q)
		else $error("first result of a pair marked as row end");

	// Taking the first of a pair leaves the row end result waiting.
	a_pair_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(res_acc && (out_cnt_q == 2'd2)) |=> ((out_cnt_q == 2'd1) && head_last_q))
		else $error("second result of a pair lost or not marked");

	// Forwarding is only ever chosen with a pixel in the read stage.
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v1_q)
		else $error("line store forwarding without a pixel");

	// A blocked multiply stage holds its pair flag.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && !s3_ready) |=> (v2_q && $stable(two_s2)))
		else $error("multiply stage lost a stalled item");

	// A row end loads a pair of results into the output counter.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(load3 && two_s2) |=> (out_cnt_q == 2'd2))
		else $error("row end did not load a result pair");

endmodule
